[rtl/core/csm_pkg.sv]
// Shared constants and types for the circular stone merge cost unit.
package csm_pkg;

   localparam int MAX_PILES_DEF   = 64;
   localparam int WEIGHT_BITS_DEF = 16;
   localparam int WEIGHT_W        = 16;
   localparam int COST_W          = 28;
   localparam logic [COST_W-1:0] COST_SAT = {COST_W{1'b1}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_ARC,
      ST_STEP,
      ST_DRAIN,
      ST_WRITE,
      ST_SCAN,
      ST_SCAN_DRAIN,
      ST_OUT
   } csm_state_type;

endpackage

[rtl/core/csm_if.sv]
// Valid/ready channel interfaces for pile items and cost results.
interface csm_req_if import csm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [WEIGHT_W-1:0] pile_weight;
   logic                last_pile;

   modport source (output valid, pile_weight, last_pile, input ready);
   modport sink   (input valid, pile_weight, last_pile, output ready);
endinterface

interface csm_rsp_if import csm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [COST_W-1:0] min_cost;
   logic [COST_W-1:0] max_cost;
   logic              too_many;

   modport source (output valid, min_cost, max_cost, too_many, input ready);
   modport sink   (input valid, min_cost, max_cost, too_many, output ready);
endinterface

[rtl/core/csm_cost_mem.sv]
// Least and greatest arc cost tables with one write port and two read ports each.
module csm_cost_mem #(
   parameter int IDX_W   = 6,
   parameter int COST_IW = 30
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [2*IDX_W-1:0]   wr_addr,
   input  logic [COST_IW-1:0]   wr_lo,
   input  logic [COST_IW-1:0]   wr_hi,
   input  logic [2*IDX_W-1:0]   rd_addr_a,
   input  logic [2*IDX_W-1:0]   rd_addr_b,
   output logic [COST_IW-1:0]   rd_lo_a,
   output logic [COST_IW-1:0]   rd_lo_b,
   output logic [COST_IW-1:0]   rd_hi_a,
   output logic [COST_IW-1:0]   rd_hi_b
);
   localparam int DEPTH = 1 << (2*IDX_W);

   logic [COST_IW-1:0] lo_mem [DEPTH];
   logic [COST_IW-1:0] hi_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lo_mem[wr_addr] <= wr_lo;
         hi_mem[wr_addr] <= wr_hi;
      end
      rd_lo_a <= lo_mem[rd_addr_a];
      rd_lo_b <= lo_mem[rd_addr_b];
      rd_hi_a <= hi_mem[rd_addr_a];
      rd_hi_b <= hi_mem[rd_addr_b];
   end
endmodule

[rtl/core/circular_stone_merge_cost_unit.sv]
// Top level: loads pile weights, then runs the circular interval merge cost search.
// Loading takes one cycle per item; piles are accepted while the unit is idle.
// After the last pile the search runs at most one table step per cycle
// through the two-read-port cost tables.
// The single result then waits in an output register until taken.
// Synchronous active-high reset clears the pile count, overflow flag and result valid.
module circular_stone_merge_cost_unit import csm_pkg::*; #(
   parameter int MAX_PILES   = MAX_PILES_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   csm_req_if.sink   req,
   csm_rsp_if.source rsp
);
   // Weights above the port width cannot arrive, so the effective width is capped.
   localparam int W_EFF    = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
   localparam int IDX_W    = (MAX_PILES > 1) ? $clog2(MAX_PILES) : 1;
   localparam int CNT_W    = $clog2(MAX_PILES + 1);
   localparam int PS_AW    = $clog2(2*MAX_PILES + 1);
   localparam int PS_DEPTH = 2*MAX_PILES + 1;
   localparam int PS_W     = W_EFF + PS_AW;
   // A total cost never exceeds the total weight times the pile count.
   localparam int COST_IW  = W_EFF + 2*CNT_W;
   localparam int XW       = COST_IW + COST_W;
   localparam logic [WEIGHT_W-1:0] WMASK = WEIGHT_W'((33'd1 << W_EFF) - 33'd1);

   csm_state_type state_ff, state_in;

   logic [CNT_W-1:0]   count_ff;
   logic               over_ff;
   logic [PS_W-1:0]    sum_ff;
   logic [IDX_W-1:0]   s_ff;
   logic [CNT_W-1:0]   len_ff;
   logic [CNT_W-1:0]   a_ff;
   logic [PS_W-1:0]    arc_ff;
   logic               arc_ld_ff;
   logic               ps_zero_ff;
   logic               init_v_ff;
   logic [IDX_W-1:0]   init_s_ff;
   logic               v1_ff, first1_ff, v2_ff, first2_ff;
   logic [COST_IW-1:0] sum2_lo_ff, sum2_hi_ff, acc_lo_ff, acc_hi_ff;
   logic               scan_v_ff, scan_first_ff;
   logic [COST_IW-1:0] best_lo_ff, best_hi_ff;
   logic               rsp_valid_ff, rsp_over_ff;
   logic [COST_W-1:0]  rsp_min_ff, rsp_max_ff;

   // Prefix sum memory: entry 0 is never written, and a read of it is treated as zero.
   logic [PS_W-1:0]  ps_mem [PS_DEPTH];
   logic [PS_W-1:0]  ps_rd_a_ff, ps_rd_b_ff;
   logic             ps_wr_en;
   logic [PS_AW-1:0] ps_wr_addr, ps_rd_addr_a, ps_rd_addr_b;
   logic [PS_W-1:0]  ps_wr_data;

   logic               tb_wr_en;
   logic [2*IDX_W-1:0] tb_wr_addr, tb_rd_addr_a, tb_rd_addr_b;
   logic [COST_IW-1:0] tb_wr_lo, tb_wr_hi;
   logic [COST_IW-1:0] rd_lo_a, rd_lo_b, rd_hi_a, rd_hi_b;

   logic               accept, store_pile;
   logic [PS_W-1:0]    weight;
   logic [CNT_W-1:0]   n_m1, s_ext;
   logic [CNT_W:0]     r_sum, r_full;
   logic [COST_IW-1:0] arc_cost, cl, ch;
   logic               load_rsp;

   assign accept     = req.valid && req.ready;
   assign store_pile = count_ff < CNT_W'(MAX_PILES);
   assign weight     = PS_W'(req.pile_weight & WMASK);
   assign n_m1       = count_ff - 1'b1;
   assign s_ext      = CNT_W'(s_ff);
   assign r_sum      = (CNT_W+1)'(s_ff) + (CNT_W+1)'(a_ff);
   // The right half of an arc wraps around the circle.
   assign r_full     = (r_sum >= (CNT_W+1)'(count_ff)) ? r_sum - (CNT_W+1)'(count_ff) : r_sum;
   assign arc_cost   = COST_IW'(arc_ff);
   assign cl         = rd_lo_a + rd_lo_b + arc_cost;
   assign ch         = rd_hi_a + rd_hi_b + arc_cost;
   assign load_rsp   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp.ready);

   assign req.ready    = (state_ff == ST_IDLE);
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.min_cost = rsp_min_ff;
   assign rsp.max_cost = rsp_max_ff;
   assign rsp.too_many = rsp_over_ff;

   // Memory port steering by phase.
   always_comb begin
      ps_wr_en     = 1'b0;
      ps_wr_addr   = PS_AW'(count_ff) + 1'b1;
      ps_wr_data   = sum_ff + weight;
      ps_rd_addr_a = PS_AW'(s_ff) + PS_AW'(len_ff);
      ps_rd_addr_b = PS_AW'(s_ff);
      tb_wr_en     = 1'b0;
      tb_wr_addr   = {s_ff, IDX_W'(len_ff - 1'b1)};
      tb_wr_lo     = acc_lo_ff;
      tb_wr_hi     = acc_hi_ff;
      tb_rd_addr_a = {s_ff, IDX_W'(a_ff - 1'b1)};
      tb_rd_addr_b = {IDX_W'(r_full), IDX_W'(len_ff - a_ff - 1'b1)};
      if (accept && store_pile) begin
         ps_wr_en = 1'b1;
      end
      // The second copy of the circle extends the prefix sums past the last pile.
      if (init_v_ff) begin
         ps_wr_en   = 1'b1;
         ps_wr_addr = PS_AW'(count_ff) + PS_AW'(init_s_ff) + 1'b1;
         ps_wr_data = sum_ff + ps_rd_a_ff;
      end
      if (state_ff == ST_INIT) begin
         ps_rd_addr_a = PS_AW'(s_ff) + 1'b1;
         tb_wr_en     = 1'b1;
         tb_wr_addr   = {s_ff, IDX_W'(0)};
         tb_wr_lo     = '0;
         tb_wr_hi     = '0;
      end
      if (state_ff == ST_WRITE) begin
         tb_wr_en = 1'b1;
      end
      if (state_ff == ST_SCAN) begin
         tb_rd_addr_a = {s_ff, IDX_W'(n_m1)};
      end
   end

   always_ff @(posedge clock) begin
      if (ps_wr_en) begin
         ps_mem[ps_wr_addr] <= ps_wr_data;
      end
      ps_rd_a_ff <= ps_mem[ps_rd_addr_a];
      ps_rd_b_ff <= ps_mem[ps_rd_addr_b];
      ps_zero_ff <= (ps_rd_addr_b == '0);
   end

   csm_cost_mem #(
      .IDX_W   (IDX_W),
      .COST_IW (COST_IW)
   ) u_cost_mem (
      .clock     (clock),
      .wr_en     (tb_wr_en),
      .wr_addr   (tb_wr_addr),
      .wr_lo     (tb_wr_lo),
      .wr_hi     (tb_wr_hi),
      .rd_addr_a (tb_rd_addr_a),
      .rd_addr_b (tb_rd_addr_b),
      .rd_lo_a   (rd_lo_a),
      .rd_lo_b   (rd_lo_b),
      .rd_hi_a   (rd_hi_a),
      .rd_hi_b   (rd_hi_b)
   );

   // Sequencer: load, extend prefix sums, arcs by length, final scan, result.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req.last_pile) state_in = ST_INIT;
         end
         ST_INIT: begin
            if (s_ext == n_m1) state_in = (count_ff == CNT_W'(1)) ? ST_SCAN : ST_ARC;
         end
         ST_ARC: state_in = ST_STEP;
         ST_STEP: begin
            if (a_ff == len_ff - 1'b1) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!v1_ff) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (s_ext == n_m1 && len_ff == count_ff) state_in = ST_SCAN;
            else state_in = ST_ARC;
         end
         ST_SCAN: begin
            if (s_ext == n_m1) state_in = ST_SCAN_DRAIN;
         end
         ST_SCAN_DRAIN: state_in = ST_OUT;
         ST_OUT: begin
            if (load_rsp) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         over_ff      <= 1'b0;
         sum_ff       <= '0;
         init_v_ff    <= 1'b0;
         arc_ld_ff    <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         scan_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         init_v_ff <= (state_ff == ST_INIT);
         arc_ld_ff <= (state_ff == ST_ARC);
         v1_ff     <= (state_ff == ST_STEP);
         v2_ff     <= v1_ff;
         scan_v_ff <= (state_ff == ST_SCAN);
         if (accept) begin
            if (store_pile) begin
               count_ff <= count_ff + 1'b1;
               sum_ff   <= sum_ff + weight;
            end else begin
               over_ff <= 1'b1;
            end
         end
         if (load_rsp) begin
            count_ff     <= '0;
            over_ff      <= 1'b0;
            sum_ff       <= '0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      init_s_ff     <= s_ff;
      first1_ff     <= (a_ff == CNT_W'(1));
      first2_ff     <= first1_ff;
      scan_first_ff <= (s_ff == '0);
      if (arc_ld_ff) begin
         arc_ff <= ps_rd_a_ff - (ps_zero_ff ? PS_W'(0) : ps_rd_b_ff);
      end
      if (v1_ff) begin
         sum2_lo_ff <= cl;
         sum2_hi_ff <= ch;
      end
      if (v2_ff) begin
         if (first2_ff || sum2_lo_ff < acc_lo_ff) acc_lo_ff <= sum2_lo_ff;
         if (first2_ff || sum2_hi_ff > acc_hi_ff) acc_hi_ff <= sum2_hi_ff;
      end
      if (scan_v_ff) begin
         if (scan_first_ff || rd_lo_a < best_lo_ff) best_lo_ff <= rd_lo_a;
         if (scan_first_ff || rd_hi_a > best_hi_ff) best_hi_ff <= rd_hi_a;
      end
      case (state_ff)
         ST_IDLE: begin
            s_ff <= '0;
         end
         ST_INIT: begin
            if (s_ext == n_m1) begin
               s_ff   <= '0;
               len_ff <= CNT_W'(2);
            end else begin
               s_ff <= s_ff + 1'b1;
            end
         end
         ST_ARC: begin
            a_ff <= CNT_W'(1);
         end
         ST_STEP: begin
            a_ff <= a_ff + 1'b1;
         end
         ST_WRITE: begin
            if (s_ext == n_m1) begin
               s_ff   <= '0;
               len_ff <= len_ff + 1'b1;
            end else begin
               s_ff <= s_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            s_ff <= s_ff + 1'b1;
         end
         default: begin
         end
      endcase
      if (load_rsp) begin
         rsp_min_ff  <= (XW'(best_lo_ff) > XW'(COST_SAT)) ? COST_SAT : COST_W'(best_lo_ff);
         rsp_max_ff  <= (XW'(best_hi_ff) > XW'(COST_SAT)) ? COST_SAT : COST_W'(best_hi_ff);
         rsp_over_ff <= over_ff;
      end
   end
endmodule

[rtl/core/csm_checker.sv]
// Port-level checks for the circular stone merge cost unit, bound to the top level.
module csm_checker import csm_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_last_pile,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [COST_W-1:0] rsp_min_cost,
   input logic [COST_W-1:0] rsp_max_cost
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_min_cost) && $stable(rsp_max_cost))
      else $error("stalled result item changed");

   a_solve_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_pile |=> !req_ready)
      else $error("input taken right after the last pile");

   a_rsp_from_solve: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without a solve");
endmodule

bind circular_stone_merge_cost_unit csm_checker u_csm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .req_last_pile (req.last_pile),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_min_cost  (rsp.min_cost),
   .rsp_max_cost  (rsp.max_cost)
);
